[hw/rtl/jsc_pkg.sv]
// Package: shared types, constants and helpers for the joystick counter display.
`default_nettype none
package jsc_pkg;

  localparam int unsigned CountW = 14;
  localparam int unsigned XW     = 10;
  localparam int unsigned NumDig = 4;

  localparam logic [CountW-1:0] COUNT_MAX = 14'd9999;
  localparam logic [XW-1:0]     HI_RESET  = 10'd1000;
  localparam logic [XW-1:0]     LO_RESET  = 10'd13;

  localparam logic REG_HIGH_THR = 1'b0;
  localparam logic REG_LOW_THR  = 1'b1;

  typedef logic [3:0] bcd_t;
  typedef bcd_t [NumDig-1:0] bcd_vec_t;

  typedef struct packed {
    logic [NumDig-1:0] digit_enable_n;
    logic [7:0]        segments;
    logic [CountW-1:0] count_value;
  } result_t;

  function automatic logic [7:0] seg_of(input bcd_t d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h27;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic bcd_vec_t bcd_inc(input bcd_vec_t v);
    bcd_vec_t r;
    logic     c;
    r = v;
    c = 1'b1;
    for (int i = 0; i < NumDig; i++) begin
      if (c) begin
        if (v[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = v[i] + 4'd1;
          c    = 1'b0;
        end
      end
    end
    return r;
  endfunction

  function automatic bcd_vec_t bcd_dec(input bcd_vec_t v);
    bcd_vec_t r;
    logic     b;
    r = v;
    b = 1'b1;
    for (int i = 0; i < NumDig; i++) begin
      if (b) begin
        if (v[i] == 4'd0) begin
          r[i] = 4'd9;
        end else begin
          r[i] = v[i] - 4'd1;
          b    = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/jsc_counter.sv]
// Input register, threshold compare, count update and digit decode.
`default_nettype none
module jsc_counter import jsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [XW-1:0]     cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_new_sample,
  input  wire logic [XW-1:0]     in_joy_x,
  input  wire logic              in_button_n,
  input  wire logic              res_ready,
  output logic                   res_push,
  output result_t                res_data
);

  logic [XW-1:0]     hi_thr_r, lo_thr_r;
  logic              s1_valid_r;
  logic              s1_new_r, s1_btn_n_r;
  logic [XW-1:0]     s1_x_r;
  logic [CountW-1:0] count_r, count_nxt;
  bcd_vec_t          bcd_r, bcd_nxt;
  logic [1:0]        scan_r;
  logic              adv, take;

  assign adv      = s1_valid_r && res_ready;
  assign in_stall = s1_valid_r && !res_ready;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_thr_r <= HI_RESET;
      lo_thr_r <= LO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH_THR: hi_thr_r <= cfg_wdata;
        REG_LOW_THR:  lo_thr_r <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take || adv) begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_new_r   <= in_new_sample;
      s1_x_r     <= in_joy_x;
      s1_btn_n_r <= in_button_n;
    end
  end

  always_comb begin
    count_nxt = count_r;
    bcd_nxt   = bcd_r;
    priority if (!s1_btn_n_r) begin
      count_nxt = '0;
      bcd_nxt   = '0;
    end else if (s1_new_r && (s1_x_r > hi_thr_r)) begin
      if (count_r < COUNT_MAX) begin
        count_nxt = count_r + 14'd1;
        bcd_nxt   = bcd_inc(bcd_r);
      end
    end else if (s1_new_r && (s1_x_r < lo_thr_r)) begin
      if (count_r != '0) begin
        count_nxt = count_r - 14'd1;
        bcd_nxt   = bcd_dec(bcd_r);
      end
    end else begin
      count_nxt = count_r;
      bcd_nxt   = bcd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bcd_r   <= '0;
      scan_r  <= '0;
    end else if (adv) begin
      count_r <= count_nxt;
      bcd_r   <= bcd_nxt;
      scan_r  <= scan_r + 2'd1;
    end
  end

  assign res_push                = adv;
  assign res_data.digit_enable_n = ~(4'b0001 << scan_r);
  assign res_data.segments       = seg_of(bcd_nxt[scan_r]);
  assign res_data.count_value    = count_nxt;

endmodule
`default_nettype wire

[hw/rtl/jsc_out_buf.sv]
// Two-entry output buffer: result register plus skid entry.
`default_nettype none
module jsc_out_buf import jsc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         ready,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      out_data
);

  logic    head_valid_r, head_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign ready     = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_data  = head_r;
  assign pop       = head_valid_r && !out_stall;

  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (!head_valid_r || pop) begin
      if (skid_valid_r) begin
        head_valid_nxt = 1'b1;
        head_nxt       = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_data;
      end else begin
        head_valid_nxt = push;
        head_nxt       = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/joystick_updown_counter_seven_segment.sv]
// Top level: joystick up/down decimal counter driving a 4-digit scanned display.
// An accepted item passes the input register and then the result register before its result is valid.
// Throughput: 1 item per cycle while out_stall is low; the result register plus a skid entry decouple out_stall.
// The count is kept in binary and BCD side by side, so digit decode is a table lookup.
// Reset (rst_n low, synchronous): count 0, scan at ones digit, thresholds 1000 and 13,
// both channels empty.
`default_nettype none
module joystick_updown_counter_seven_segment import jsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [XW-1:0]     cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_new_sample,
  input  wire logic [XW-1:0]     in_joy_x,
  input  wire logic              in_button_n,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [NumDig-1:0]      out_digit_enable_n,
  output logic [7:0]             out_segments,
  output logic [CountW-1:0]      out_count_value
);

  logic    res_ready, res_push;
  result_t res_data, out_data;

  jsc_counter u_counter (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_new_sample (in_new_sample),
    .in_joy_x      (in_joy_x),
    .in_button_n   (in_button_n),
    .res_ready     (res_ready),
    .res_push      (res_push),
    .res_data      (res_data)
  );

  jsc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .ready     (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_digit_enable_n = out_data.digit_enable_n;
  assign out_segments       = out_data.segments;
  assign out_count_value    = out_data.count_value;

endmodule
`default_nettype wire
